/* rtl/njdr_pkg.sv */
package njdr_pkg;

   localparam int unsigned PT_W     = 14;
   localparam int unsigned ETA_W    = 14;
   localparam int unsigned PHI_W    = 13;
   localparam int unsigned DIST_W   = 27;
   localparam int unsigned ROOT_STEPS = 14;
   localparam int unsigned STEP_W   = 4;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W   = 1;

   localparam logic signed [PHI_W:0] PI_Q     = 14'sd3217;
   localparam logic signed [PHI_W:0] TWO_PI_Q = 14'sd6434;
   localparam logic [DIST_W-1:0]     DIST_MAX = '1;
   localparam logic [PT_W-1:0]       PT_MAX   = '1;
   localparam logic [PT_W-1:0]       THRESHOLD_RESET = 14'd120;

   typedef struct packed {
      logic [DIST_W-1:0] dist_sq;
      logic [PT_W-1:0]   pt;
      logic              found;
   } njdr_entry_type;

endpackage

/* rtl/njdr_if.sv */
interface njdr_req_if;
   import njdr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [PT_W-1:0]         jet_pt;
   logic signed [ETA_W-1:0] jet_eta;
   logic signed [PHI_W-1:0] jet_phi;
   logic signed [ETA_W-1:0] lepton_eta;
   logic signed [PHI_W-1:0] lepton_phi;
   logic                    jet_present;
   logic                    last_jet;
   modport source (output valid, jet_pt, jet_eta, jet_phi, lepton_eta, lepton_phi,
                   jet_present, last_jet, input ready);
   modport sink   (input valid, jet_pt, jet_eta, jet_phi, lepton_eta, lepton_phi,
                   jet_present, last_jet, output ready);
endinterface

interface njdr_rsp_if;
   import njdr_pkg::*;
   logic            valid;
   logic            ready;
   logic [PT_W-1:0] min_delta_r;
   logic [PT_W-1:0] matched_jet_pt;
   logic            match_found;
   modport source (output valid, min_delta_r, matched_jet_pt, match_found, input ready);
   modport sink   (input valid, min_delta_r, matched_jet_pt, match_found, output ready);
endinterface

interface njdr_csr_if;
   import njdr_pkg::*;
   logic            valid;
   logic            ready;
   logic [PT_W-1:0] jet_pt_threshold;
   modport source (output valid, jet_pt_threshold, input ready);
   modport sink   (input valid, jet_pt_threshold, output ready);
endinterface

/* rtl/njdr_front.sv */
module njdr_front
   import njdr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   njdr_req_if.sink       req,
   njdr_csr_if.sink       csr,
   output logic           push_valid,
   input  logic           push_ready,
   output njdr_entry_type push_data
);

   logic [PT_W-1:0] threshold_ff;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_qual_ff, s1_qual_in;
   logic                    s1_last_ff;
   logic [PT_W-1:0]         s1_pt_ff;
   logic signed [ETA_W:0]   s1_deta_ff, s1_deta_in;
   logic signed [PHI_W-1:0] s1_dphi_ff, s1_dphi_in;
   logic signed [PHI_W:0]   dphi_raw;
   logic signed [PHI_W:0]   dphi_wrap;

   logic                    s2_valid_ff, s2_qual_ff, s2_last_ff;
   logic [PT_W-1:0]         s2_pt_ff;
   logic [28:0]             s2_sq_eta_ff, s2_sq_eta_in;
   logic [23:0]             s2_sq_phi_ff, s2_sq_phi_in;
   logic signed [29:0]      prod_eta;
   logic signed [25:0]      prod_phi;

   logic                    s3_valid_ff, s3_qual_ff, s3_last_ff;
   logic [PT_W-1:0]         s3_pt_ff;
   logic [DIST_W-1:0]       s3_dist_ff, s3_dist_in;
   logic [29:0]             dist_sum;

   logic [DIST_W-1:0]       best_dist_ff;
   logic [PT_W-1:0]         best_pt_ff;
   logic                    any_ff;
   logic                    take;
   logic                    advance;
   njdr_entry_type          cur;

   assign advance   = !(s3_valid_ff && s3_last_ff && !push_ready);
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   always_comb begin
      s1_valid_in = req.valid;
      s1_qual_in  = req.jet_present && (req.jet_pt >= threshold_ff);
      s1_deta_in  = {req.jet_eta[ETA_W-1], req.jet_eta}
                  - {req.lepton_eta[ETA_W-1], req.lepton_eta};
      dphi_raw    = {req.jet_phi[PHI_W-1], req.jet_phi}
                  - {req.lepton_phi[PHI_W-1], req.lepton_phi};
      if (dphi_raw >= PI_Q) begin
         dphi_wrap = dphi_raw - TWO_PI_Q;
      end else if (dphi_raw < -PI_Q) begin
         dphi_wrap = dphi_raw + TWO_PI_Q;
      end else begin
         dphi_wrap = dphi_raw;
      end
      s1_dphi_in = dphi_wrap[PHI_W-1:0];
   end

   always_comb begin
      prod_eta     = s1_deta_ff * s1_deta_ff;
      prod_phi     = s1_dphi_ff * s1_dphi_ff;
      s2_sq_eta_in = prod_eta[28:0];
      s2_sq_phi_in = prod_phi[23:0];
   end

   always_comb begin
      dist_sum = {1'b0, s2_sq_eta_ff} + {6'd0, s2_sq_phi_ff};
      if (dist_sum[29:DIST_W] != 3'd0) begin
         s3_dist_in = DIST_MAX;
      end else begin
         s3_dist_in = dist_sum[DIST_W-1:0];
      end
   end

   always_comb begin
      take = s3_valid_ff && s3_qual_ff && (!any_ff || (s3_dist_ff < best_dist_ff));
      cur.dist_sq = take ? s3_dist_ff : best_dist_ff;
      cur.pt      = take ? s3_pt_ff : best_pt_ff;
      cur.found   = any_ff || take;
   end

   assign push_valid = s3_valid_ff && s3_last_ff;
   assign push_data  = cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr.valid) begin
         threshold_ff <= csr.jet_pt_threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_qual_ff   <= s1_qual_in;
         s1_last_ff   <= req.last_jet;
         s1_pt_ff     <= req.jet_pt;
         s1_deta_ff   <= s1_deta_in;
         s1_dphi_ff   <= s1_dphi_in;
         s2_qual_ff   <= s1_qual_ff;
         s2_last_ff   <= s1_last_ff;
         s2_pt_ff     <= s1_pt_ff;
         s2_sq_eta_ff <= s2_sq_eta_in;
         s2_sq_phi_ff <= s2_sq_phi_in;
         s3_qual_ff   <= s2_qual_ff;
         s3_last_ff   <= s2_last_ff;
         s3_pt_ff     <= s2_pt_ff;
         s3_dist_ff   <= s3_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= DIST_MAX;
         best_pt_ff   <= PT_MAX;
         any_ff       <= 1'b0;
      end else if (advance && s3_valid_ff) begin
         if (s3_last_ff) begin
            best_dist_ff <= DIST_MAX;
            best_pt_ff   <= PT_MAX;
            any_ff       <= 1'b0;
         end else begin
            best_dist_ff <= cur.dist_sq;
            best_pt_ff   <= cur.pt;
            any_ff       <= cur.found;
         end
      end
   end

endmodule

/* rtl/njdr_queue.sv */
module njdr_queue
   import njdr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  njdr_entry_type push_data,
   output logic           pop_valid,
   input  logic           pop_ready,
   output njdr_entry_type pop_data
);

   njdr_entry_type      mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_DEPTH[QPTR_W:0]);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/njdr_back.sv */
module njdr_back
   import njdr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  njdr_entry_type pop_data,
   njdr_rsp_if.source     rsp
);

   typedef enum logic [1:0] {IDLE, CALC, DONE} state_type;

   state_type         state_ff;
   logic [DIST_W-1:0] rem_ff, root_ff;
   logic [STEP_W-1:0] step_ff;
   logic [PT_W-1:0]   pt_ff;
   logic              found_ff;
   logic              rsp_valid_ff;
   logic [PT_W-1:0]   min_delta_r_ff, matched_jet_pt_ff;
   logic              match_found_ff;

   logic [DIST_W-1:0] bit_val;
   logic [DIST_W:0]   trial;
   logic              fits;

   assign pop_ready = (state_ff == IDLE);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.min_delta_r    = min_delta_r_ff;
   assign rsp.matched_jet_pt = matched_jet_pt_ff;
   assign rsp.match_found    = match_found_ff;

   always_comb begin
      bit_val = DIST_W'(1) << {step_ff, 1'b0};
      trial   = {1'b0, root_ff} + {1'b0, bit_val};
      fits    = ({1'b0, rem_ff} >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == DONE && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (pop_valid) begin
                  rem_ff   <= pop_data.dist_sq;
                  root_ff  <= '0;
                  step_ff  <= STEP_W'(ROOT_STEPS - 1);
                  pt_ff    <= pop_data.pt;
                  found_ff <= pop_data.found;
                  state_ff <= CALC;
               end
            end
            CALC: begin
               if (fits) begin
                  rem_ff  <= rem_ff - trial[DIST_W-1:0];
                  root_ff <= (root_ff >> 1) + bit_val;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               if (step_ff == '0) begin
                  state_ff <= DONE;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  min_delta_r_ff    <= found_ff ? root_ff[PT_W-1:0] : PT_MAX;
                  matched_jet_pt_ff <= found_ff ? pt_ff : PT_MAX;
                  match_found_ff    <= found_ff;
                  state_ff          <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/nearest_jet_delta_r_match.sv */
// Jets are taken one beat per cycle, except that the front stalls while a finished
// event waits for room in the queue; a three-stage front pipeline forms the distance.
// The back end computes the square root bit by bit and takes no new event result
// until it is idle again; a two-entry queue holds results of events that finish sooner.
// Synchronous reset clears the pipeline, the queue and the event state, and sets the
// threshold register to 120.
module nearest_jet_delta_r_match
   import njdr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   njdr_req_if.sink   req,
   njdr_rsp_if.source rsp,
   njdr_csr_if.sink   csr
);

   logic           push_valid, push_ready;
   njdr_entry_type push_data;
   logic           pop_valid, pop_ready;
   njdr_entry_type pop_data;

   njdr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   njdr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   njdr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp)
   );

endmodule
